@@ rtl/ecnf_pkg.sv @@
`timescale 1ns / 1ps
// shared types, constants and list compare function for the class nano filter
// no dependencies; imported by ecm_class_nano_filter
package ecnf_pkg;

   localparam int MAX_CLASSES   = 8;
   localparam int MAX_MSG_BYTES = 512;
   localparam int POS_W         = $clog2(MAX_MSG_BYTES);
   localparam int CLASS_W       = 8;
   localparam int LIST_W        = 64;
   localparam int COUNT_W       = 4;
   localparam int CAID_W        = 16;

   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_IDX_W  = 2;

   localparam logic [CLASS_W-1:0] TAG_CLASS      = 8'hE2;
   localparam logic [CLASS_W-1:0] TAG_END        = 8'hEA;
   localparam logic [CLASS_W-1:0] LATE_MARK      = 8'hD2;
   localparam logic [CAID_W-1:0]  FILTER_CAID    = 16'h0500;
   localparam logic [POS_W-1:0]   MARK_POS       = POS_W'(4);
   localparam logic [POS_W-1:0]   START_EARLY    = POS_W'(9);
   localparam logic [POS_W-1:0]   START_LATE     = POS_W'(12);
   localparam logic [POS_W-1:0]   POS_MAX        = POS_W'(MAX_MSG_BYTES - 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BLOCKED_COUNT   = 2'd0,
      CSR_BLOCKED_CLASSES = 2'd1,
      CSR_ALLOWED_COUNT   = 2'd2,
      CSR_ALLOWED_CLASSES = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_SCAN = 2'd1,
      MODE_LEN  = 2'd2,
      MODE_BODY = 2'd3
   } parse_mode_type;

   typedef enum logic [2:0] {
      VERDICT_NOT_FILTERED = 3'd0,
      VERDICT_PASS_NO_CHECK = 3'd1,
      VERDICT_PASS_ALLOWED = 3'd2,
      VERDICT_BLOCKED      = 3'd3,
      VERDICT_NO_ALLOWED   = 3'd4
   } verdict_type;

   typedef struct packed {
      logic [CAID_W-1:0]  ca_system_id;
      logic               last_byte;
      logic [CLASS_W-1:0] msg_byte;
   } req_item_type;

   typedef struct packed {
      verdict_type verdict;
      logic        accepted;
   } rsp_item_type;

   function automatic logic list_has(input logic [COUNT_W-1:0] count,
                                     input logic [LIST_W-1:0]  packed_list,
                                     input logic [CLASS_W-1:0] cls);
      logic hit;
      hit = 1'b0;
      for (int i = 0; i < MAX_CLASSES; i++) begin
         if ((32'(count) > i) && (packed_list[CLASS_W*i +: CLASS_W] == cls)) begin
            hit = 1'b1;
         end
      end
      return hit;
   endfunction

endpackage

@@ rtl/ecm_class_nano_filter.sv @@
`timescale 1ns / 1ps
// class filter for access-control messages: byte parser, class lists, verdict
// depends on ecnf_pkg
//
// The block takes one message byte per clock cycle unless input is held back,
// and returns one verdict transfer for each byte marked with tlast. A byte is
// first captured in an input register; when it advances, the parse state
// (position, mode, tag body count and hit flags) is updated by a single pass
// of logic that includes the parallel compare of the byte against both
// eight-entry class lists, and a last byte clears it and loads the verdict
// register that drives rsp_tvalid. Throughput is one byte per cycle unless
// input is held back. Input is only held back while a verdict waits in the
// output register and the next last byte is ready to retire. The user must
// write class lists through the csr port only while no message is in flight;
// the block does not enforce this.
module ecm_class_nano_filter (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,   // msg_byte
   input  logic                                req_tlast,   // last_byte
   input  logic [ecnf_pkg::CAID_W-1:0]         req_tuser,   // ca_system_id
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [7:0]                          rsp_tdata,   // accepted, verdict[2:0], zeros
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [ecnf_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [ecnf_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [ecnf_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);
   import ecnf_pkg::*;

   logic [COUNT_W-1:0] blocked_count_ff, allowed_count_ff;
   logic [LIST_W-1:0]  blocked_classes_ff, allowed_classes_ff;
   logic               csr_write;
   csr_index_type      csr_index;

   logic               s1_valid_ff;
   req_item_type       s1_item_ff;
   logic               s1_advance;

   logic [POS_W-1:0]   pos_ff, pos_in;
   parse_mode_type     mode_ff, mode_in;
   logic [7:0]         body_ff, body_in;
   logic               late_ff, late_in;
   logic               filter_ff, filter_in;
   logic               seen_ff, seen_in;
   logic               allowed_hit_ff, allowed_hit_in;
   logic               blocked_hit_ff, blocked_hit_in;

   logic               rsp_valid_ff;
   rsp_item_type       rsp_item_ff, rsp_item_in;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_index_type'(csr_paddr[CSR_ADDR_W-1:CSR_ADDR_W-CSR_IDX_W]);

   always_ff @(posedge clock) begin
      if (reset) begin
         blocked_count_ff   <= '0;
         blocked_classes_ff <= '0;
         allowed_count_ff   <= '0;
         allowed_classes_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_BLOCKED_COUNT:   blocked_count_ff   <= csr_pwdata[COUNT_W-1:0];
            CSR_BLOCKED_CLASSES: blocked_classes_ff <= csr_pwdata[LIST_W-1:0];
            CSR_ALLOWED_COUNT:   allowed_count_ff   <= csr_pwdata[COUNT_W-1:0];
            CSR_ALLOWED_CLASSES: allowed_classes_ff <= csr_pwdata[LIST_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         CSR_BLOCKED_COUNT:   csr_prdata = CSR_DATA_W'(blocked_count_ff);
         CSR_BLOCKED_CLASSES: csr_prdata = CSR_DATA_W'(blocked_classes_ff);
         CSR_ALLOWED_COUNT:   csr_prdata = CSR_DATA_W'(allowed_count_ff);
         CSR_ALLOWED_CLASSES: csr_prdata = CSR_DATA_W'(allowed_classes_ff);
         default:             csr_prdata = '0;
      endcase
   end

   // input register
   assign s1_advance = s1_valid_ff && (!s1_item_ff.last_byte || !rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s1_item_ff.msg_byte     <= req_tdata;
         s1_item_ff.last_byte    <= req_tlast;
         s1_item_ff.ca_system_id <= req_tuser;
      end
   end

   // parse state next value
   always_comb begin
      logic [CLASS_W-1:0] b;
      logic [POS_W-1:0]   start;
      logic               first;
      logic               take;
      b     = s1_item_ff.msg_byte;
      first = (pos_ff == '0);
      take  = 1'b0;

      pos_in         = (pos_ff < POS_MAX) ? pos_ff + POS_W'(1) : pos_ff;
      mode_in        = first ? MODE_IDLE : mode_ff;
      body_in        = first ? '0 : body_ff;
      late_in        = first ? 1'b0 : late_ff;
      filter_in      = first ? (s1_item_ff.ca_system_id == FILTER_CAID) : filter_ff;
      seen_in        = first ? 1'b0 : seen_ff;
      allowed_hit_in = first ? 1'b0 : allowed_hit_ff;
      blocked_hit_in = first ? 1'b0 : blocked_hit_ff;

      if (pos_ff == MARK_POS) begin
         late_in = (b == LATE_MARK);
      end
      start = late_in ? START_LATE : START_EARLY;

      case (mode_in)
         MODE_IDLE: begin
            if (pos_ff == start) begin
               mode_in = (b == TAG_CLASS) ? MODE_LEN :
                         (b == TAG_END)   ? MODE_IDLE : MODE_SCAN;
            end
         end
         MODE_SCAN: begin
            mode_in = (b == TAG_CLASS) ? MODE_LEN :
                      (b == TAG_END)   ? MODE_IDLE : MODE_SCAN;
         end
         MODE_LEN: begin
            if (b == '0) begin
               take = 1'b1;
            end else begin
               body_in = b;
               mode_in = MODE_BODY;
            end
         end
         MODE_BODY: begin
            if (body_in > 8'd1) begin
               body_in = body_in - 8'd1;
            end else begin
               body_in = '0;
               take    = 1'b1;
            end
         end
         default: mode_in = MODE_IDLE;
      endcase

      // class byte: check lists, rescan it unless halted
      if (take) begin
         if (list_has(blocked_count_ff, blocked_classes_ff, b)) begin
            blocked_hit_in = 1'b1;
            mode_in        = MODE_IDLE;
         end else begin
            seen_in = 1'b1;
            if (list_has(allowed_count_ff, allowed_classes_ff, b)) begin
               allowed_hit_in = 1'b1;
            end
            mode_in = (b == TAG_CLASS) ? MODE_LEN :
                      (b == TAG_END)   ? MODE_IDLE : MODE_SCAN;
         end
      end
   end

   // verdict from the state after this byte
   always_comb begin
      if (!filter_in || (blocked_count_ff == '0 && allowed_count_ff == '0)) begin
         rsp_item_in.accepted = 1'b1;
         rsp_item_in.verdict  = VERDICT_NOT_FILTERED;
      end else if (blocked_hit_in) begin
         rsp_item_in.accepted = 1'b0;
         rsp_item_in.verdict  = VERDICT_BLOCKED;
      end else if (seen_in && allowed_count_ff != '0) begin
         rsp_item_in.accepted = allowed_hit_in;
         rsp_item_in.verdict  = allowed_hit_in ? VERDICT_PASS_ALLOWED : VERDICT_NO_ALLOWED;
      end else begin
         rsp_item_in.accepted = 1'b1;
         rsp_item_in.verdict  = VERDICT_PASS_NO_CHECK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff         <= '0;
         mode_ff        <= MODE_IDLE;
         body_ff        <= '0;
         late_ff        <= 1'b0;
         filter_ff      <= 1'b0;
         seen_ff        <= 1'b0;
         allowed_hit_ff <= 1'b0;
         blocked_hit_ff <= 1'b0;
      end else if (s1_advance) begin
         if (s1_item_ff.last_byte) begin
            pos_ff         <= '0;
            mode_ff        <= MODE_IDLE;
            body_ff        <= '0;
            late_ff        <= 1'b0;
            filter_ff      <= 1'b0;
            seen_ff        <= 1'b0;
            allowed_hit_ff <= 1'b0;
            blocked_hit_ff <= 1'b0;
         end else begin
            pos_ff         <= pos_in;
            mode_ff        <= mode_in;
            body_ff        <= body_in;
            late_ff        <= late_in;
            filter_ff      <= filter_in;
            seen_ff        <= seen_in;
            allowed_hit_ff <= allowed_hit_in;
            blocked_hit_ff <= blocked_hit_in;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_advance && s1_item_ff.last_byte) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance && s1_item_ff.last_byte) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_item_ff};

`ifndef SYNTHESIS
   a_body_only_in_tag: assert property (@(posedge clock) disable iff (reset)
      mode_ff != MODE_BODY |-> body_ff == '0)
      else $error("tag body count left outside tag body");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      s1_advance && s1_item_ff.last_byte |=> pos_ff == '0 && mode_ff == MODE_IDLE)
      else $error("message state not cleared after last byte");

   a_fresh_message_clear: assert property (@(posedge clock) disable iff (reset)
      pos_ff == '0 |-> !seen_ff && !allowed_hit_ff && !blocked_hit_ff && !late_ff)
      else $error("stale flags at message start");

   a_blocked_halts: assert property (@(posedge clock) disable iff (reset)
      blocked_hit_ff |-> mode_ff == MODE_IDLE)
      else $error("scanning continued after blocked class");

   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_advance && s1_item_ff.last_byte))
      else $error("verdict without a last byte");
`endif

endmodule
